FILE: rtl/register_breakpoint_table_defines.svh
// assertion macros for the breakpoint table rtl
// needs clk_i and rst_ni in the scope that uses them
`ifndef REGISTER_BREAKPOINT_TABLE_DEFINES_SVH
`define REGISTER_BREAKPOINT_TABLE_DEFINES_SVH

`ifndef ASSERT_OFF
// checked outside reset only
`define RBT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// checked during reset too
`define RBT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define RBT_ASSERT(label, prop, msg)
`define RBT_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

FILE: rtl/rbt_pkg.sv
// types, codes and the entry compare function for the breakpoint table
// no dependencies
package rbt_pkg;

  localparam int unsigned RbtEntries = 10;

  typedef enum logic [2:0] {
    KindSet      = 3'd0,
    KindSetStack = 3'd1,
    KindClear    = 3'd2,
    KindClearAll = 3'd3,
    KindCheck    = 3'd4
  } rbt_kind_e;

  typedef enum logic [1:0] {
    StatusDone    = 2'd0,
    StatusFull    = 2'd1,
    StatusNoClear = 2'd2
  } rbt_status_e;

  // register selector codes
  localparam logic [4:0] SelA     = 5'd0;
  localparam logic [4:0] SelB     = 5'd1;
  localparam logic [4:0] SelC     = 5'd2;
  localparam logic [4:0] SelD     = 5'd3;
  localparam logic [4:0] SelE     = 5'd4;
  localparam logic [4:0] SelH     = 5'd5;
  localparam logic [4:0] SelL     = 5'd6;
  localparam logic [4:0] SelAf    = 5'd7;
  localparam logic [4:0] SelBc    = 5'd8;
  localparam logic [4:0] SelDe    = 5'd9;
  localparam logic [4:0] SelHl    = 5'd10;
  localparam logic [4:0] SelSp    = 5'd11;
  localparam logic [4:0] SelPc    = 5'd12;
  localparam logic [4:0] SelLy    = 5'd13;
  localparam logic [4:0] SelFlagZ = 5'd14;
  localparam logic [4:0] SelFlagN = 5'd15;
  localparam logic [4:0] SelFlagH = 5'd16;
  localparam logic [4:0] SelFlagC = 5'd17;
  localparam logic [4:0] SelCount = 5'd18;
  localparam logic [4:0] SelStack = 5'd18;

  typedef struct packed {
    logic [2:0]  kind;
    logic [4:0]  reg_select;
    logic [15:0] match_value;
    logic [15:0] snap_af;
    logic [15:0] snap_bc;
    logic [15:0] snap_de;
    logic [15:0] snap_hl;
    logic [15:0] snap_sp;
    logic [15:0] snap_pc;
    logic [7:0]  snap_line;
  } rbt_in_t;

  typedef struct packed {
    logic       hit;
    logic [3:0] hit_slot;
    logic [1:0] status;
  } rbt_out_t;

  // does one stored entry fire against the register snapshot
  function automatic logic entry_match(logic [4:0] sel, logic [15:0] val, rbt_in_t item);
    logic want;
    logic res;
    want = (val != 16'd0);
    unique case (sel)
      SelA:     res = ({8'd0, item.snap_af[15:8]} == val);
      SelB:     res = ({8'd0, item.snap_bc[15:8]} == val);
      SelC:     res = ({8'd0, item.snap_bc[7:0]} == val);
      SelD:     res = ({8'd0, item.snap_de[15:8]} == val);
      SelE:     res = ({8'd0, item.snap_de[7:0]} == val);
      SelH:     res = ({8'd0, item.snap_hl[15:8]} == val);
      SelL:     res = ({8'd0, item.snap_hl[7:0]} == val);
      SelAf:    res = (item.snap_af == val);
      SelBc:    res = (item.snap_bc == val);
      SelDe:    res = (item.snap_de == val);
      SelHl:    res = (item.snap_hl == val);
      SelSp:    res = (item.snap_sp == val);
      SelPc:    res = (item.snap_pc == val);
      SelLy:    res = ({8'd0, item.snap_line} == val);
      SelFlagZ: res = (item.snap_af[7] == want);
      SelFlagN: res = (item.snap_af[6] == want);
      SelFlagH: res = (item.snap_af[5] == want);
      SelFlagC: res = (item.snap_af[4] == want);
      SelStack: res = (item.snap_sp != val);
      default:  res = 1'b0;
    endcase
    return res;
  endfunction

endpackage

FILE: rtl/register_breakpoint_table.sv
// channel | signals                        | payload
// in      | in_valid_i / in_ready_o        | rbt_in_t  in_data_i
// out     | out_valid_o / out_ready_i      | rbt_out_t out_data_o
//
// one item per clock while the output is not stalled: an item is first held in the
// input register, then the table lookup, priority pick and table update happen as
// it moves to the result register.
// reset clears all valid bits and both stage valids; entry payloads are not reset.
// a stalled output holds the result and backs up the input register.
//
// breakpoint table top level, uses rbt_pkg and register_breakpoint_table_defines.svh
`include "register_breakpoint_table_defines.svh"

module register_breakpoint_table
  import rbt_pkg::*;
#(
  parameter int unsigned ENTRIES = RbtEntries
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  rbt_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output rbt_out_t out_data_o
);

  localparam int unsigned IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  logic                in_valid_q;
  rbt_in_t             in_q;
  logic                out_valid_q;
  rbt_out_t            out_q;
  logic [ENTRIES-1:0]  valid_q, valid_d;
  logic [4:0]          sel_q [ENTRIES];
  logic [15:0]         value_q [ENTRIES];

  logic                move;
  logic                free_found, clr_found, hit_found;
  logic [IdxW-1:0]     free_idx, clr_idx, hit_idx;
  logic                wr_en;
  logic [4:0]          wr_sel;
  logic [15:0]         wr_value;
  rbt_out_t            out_d;
  logic [IdxW+3:0]     slot_ext;

  assign move       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || move;

  // lowest-index priority picks, iterating downward so the lowest wins
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    clr_found  = 1'b0;
    clr_idx    = '0;
    hit_found  = 1'b0;
    hit_idx    = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_found = 1'b1;
        free_idx   = IdxW'(i);
      end
      if (valid_q[i] && (sel_q[i] == in_q.reg_select)) begin
        clr_found = 1'b1;
        clr_idx   = IdxW'(i);
      end
      if (valid_q[i] && entry_match(sel_q[i], value_q[i], in_q)) begin
        hit_found = 1'b1;
        hit_idx   = IdxW'(i);
      end
    end
  end

  always_comb begin
    valid_d      = valid_q;
    wr_en        = 1'b0;
    wr_sel       = in_q.reg_select;
    wr_value     = in_q.match_value;
    out_d.hit    = 1'b0;
    out_d.status = StatusDone;
    slot_ext     = '0;
    unique case (in_q.kind)
      KindSet: begin
        if (in_q.reg_select < SelCount) begin
          if (free_found) begin
            wr_en             = 1'b1;
            valid_d[free_idx] = 1'b1;
          end else begin
            out_d.status = StatusFull;
          end
        end
      end
      KindSetStack: begin
        wr_sel   = SelStack;
        wr_value = in_q.snap_sp;
        if (free_found) begin
          wr_en             = 1'b1;
          valid_d[free_idx] = 1'b1;
        end else begin
          out_d.status = StatusFull;
        end
      end
      KindClear: begin
        // stack entries share no user selector, so the range check keeps them safe
        if ((in_q.reg_select < SelCount) && clr_found) begin
          valid_d[clr_idx] = 1'b0;
        end else begin
          out_d.status = StatusNoClear;
        end
      end
      KindClearAll: begin
        valid_d = '0;
      end
      KindCheck: begin
        if (hit_found) begin
          valid_d[hit_idx] = 1'b0;
          out_d.hit        = 1'b1;
          slot_ext         = {4'd0, hit_idx};
        end
      end
      default: ;
    endcase
    out_d.hit_slot = slot_ext[3:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      valid_q     <= '0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (move) begin
        out_valid_q <= 1'b1;
        valid_q     <= valid_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
    if (move) begin
      out_q <= out_d;
    end
    if (move && wr_en) begin
      sel_q[free_idx]   <= wr_sel;
      value_q[free_idx] <= wr_value;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `RBT_ASSERT(a_hit_frees_entry, move && (in_q.kind == KindCheck) && hit_found |=> !valid_q[$past(hit_idx)], "fired entry still valid")
  `RBT_ASSERT(a_full_only_when_full, move && (out_d.status == StatusFull) |-> (&valid_q), "table full reported with a free entry")
  `RBT_ASSERT(a_hit_has_done_status, out_valid_o && out_data_o.hit |-> (out_data_o.status == StatusDone), "hit with non-done status")
  `RBT_ASSERT_ALWAYS(a_reset_empties_table, !rst_ni |=> (valid_q == '0) || rst_ni, "valid bits survive reset")

endmodule
